[src/ttrrd_pkg.sv]
// ----------------------------------------------------------------------------
// ttrrd_pkg
// Shared constants for the task table round-robin dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package ttrrd_pkg;

    localparam int MAX_TASKS_DEF = 8;
    localparam int KEY_BITS_DEF  = 32;

    // command opcodes
    localparam logic [2:0] OP_CREATE   = 3'd0;
    localparam logic [2:0] OP_START    = 3'd1;
    localparam logic [2:0] OP_STOP     = 3'd2;
    localparam logic [2:0] OP_DISPATCH = 3'd3;
    localparam logic [2:0] OP_REPORT   = 3'd4;

    // task status
    localparam logic [1:0] ST_WAITING = 2'd0;
    localparam logic [1:0] ST_EXITED  = 2'd2;
    localparam logic [1:0] ST_ENDED   = 2'd3;

    // result codes
    localparam logic [2:0] RC_OK     = 3'd0;
    localparam logic [2:0] RC_FULL   = 3'd1;
    localparam logic [2:0] RC_EXISTS = 3'd2;
    localparam logic [2:0] RC_RANGE  = 3'd3;
    localparam logic [2:0] RC_NONE   = 3'd4;

endpackage

`default_nettype wire

[src/task_table_round_robin_dispatch.sv]
// ----------------------------------------------------------------------------
// task_table_round_robin_dispatch
// Task slot table with key lookup on create and round-robin dispatch.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (opcode, task_key, slot_id, new_status) is taken at a
//   clock edge with start high and busy low. Every command gives exactly one
//   result word on result_slot/result_code, shown for one cycle with done
//   high. The receiver cannot stall; results are never held back.
//   Command flow:
//     start, stop, report, unused opcodes, create into an empty or full
//     table: done in the following cycle, next command may follow at once.
//     create with N created slots: one key RAM read per slot, pipelined
//     behind the registered read data; ends at slot k when it holds the
//     key, after all N slots when the key is new.
//     dispatch: ends at the k-th slot scanned (k from 0) when it is taken,
//     after all MAX_TASKS slots when nothing is runnable.
//   The scan rate is set by the single read port of the key and status
//   RAMs: one slot per cycle.
//   Reset: task count, scan start and running slot go to zero; every
//   status reads as waiting through valid bits, no clearing pass needed.
//   Key entries are undefined until created.
// ----------------------------------------------------------------------------
`default_nettype none

module task_table_round_robin_dispatch #(
    parameter int MAX_TASKS = ttrrd_pkg::MAX_TASKS_DEF,
    parameter int KEY_BITS  = ttrrd_pkg::KEY_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  opcode,
    input  wire logic [31:0] task_key,
    input  wire logic [7:0]  slot_id,
    input  wire logic [1:0]  new_status,
    output logic             done,
    output logic      [2:0]  result_slot,
    output logic      [2:0]  result_code
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CSCAN = 3'b010,   // create: search keys of created slots
        S_DSCAN = 3'b100    // dispatch: cyclic scan for a runnable slot
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    scan_reg, scan_next;
    logic [IDX_W-1:0]    run_reg, run_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [IDX_W-1:0]    iss_idx_reg, iss_idx_next;   // RAM read address
    logic [CNT_W-1:0]    iss_cnt_reg, iss_cnt_next;   // reads issued
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;   // slot of data on RAM out
    logic [CNT_W-1:0]    cmp_cnt_reg, cmp_cnt_next;   // slots checked
    logic                pend_reg, pend_next;         // RAM out holds fresh data
    logic                done_reg, done_next;
    logic [2:0]          rslot_reg, rslot_next;
    logic [2:0]          rcode_reg, rcode_next;

    // memory ports
    logic                key_we;
    logic [IDX_W-1:0]    key_waddr;
    logic [KEY_BITS-1:0] key_wdata;
    logic [KEY_BITS-1:0] key_q;
    logic                st_we;
    logic [IDX_W-1:0]    st_waddr;
    logic [1:0]          st_wdata;
    logic [1:0]          st_q;

    // helpers
    logic [KEY_BITS+31:0] key_ext;
    logic [KEY_BITS-1:0]  key_in;
    logic [IDX_W+2:0]     cmp_ext, run_ext;
    logic [CNT_W+2:0]     cnt_ext;
    logic [IDX_W-1:0]     iss_wrap, cmp_wrap;
    logic [CNT_W-1:0]     limit, last_cnt;
    logic                 runnable, hit;

    assign key_ext  = {{KEY_BITS{1'b0}}, task_key};
    assign key_in   = key_ext[KEY_BITS-1:0];
    assign cmp_ext  = {3'b000, cmp_idx_reg};
    assign run_ext  = {3'b000, run_reg};
    assign cnt_ext  = {3'b000, count_reg};
    assign iss_wrap = (iss_idx_reg == IDX_W'(MAX_TASKS - 1)) ? '0 : iss_idx_reg + 1'b1;
    assign cmp_wrap = (cmp_idx_reg == IDX_W'(MAX_TASKS - 1)) ? '0 : cmp_idx_reg + 1'b1;
    assign limit    = (state_reg == S_CSCAN) ? count_reg : CNT_W'(MAX_TASKS);
    assign last_cnt = limit - CNT_W'(1);

    assign runnable = (CNT_W'(cmp_idx_reg) < count_reg) && (key_q != '0)
                   && (st_q != ttrrd_pkg::ST_EXITED) && (st_q != ttrrd_pkg::ST_ENDED);
    assign hit      = (state_reg == S_CSCAN) ? (key_q == key_reg) : runnable;

    ttrrd_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (MAX_TASKS)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (iss_idx_reg),
        .rdata (key_q)
    );

    ttrrd_stat #(
        .DEPTH (MAX_TASKS)
    ) u_stat (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (iss_idx_reg),
        .rdata (st_q)
    );

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        scan_next    = scan_reg;
        run_next     = run_reg;
        key_next     = key_reg;
        iss_idx_next = iss_idx_reg;
        iss_cnt_next = iss_cnt_reg;
        cmp_idx_next = cmp_idx_reg;
        cmp_cnt_next = cmp_cnt_reg;
        pend_next    = 1'b0;
        done_next    = 1'b0;
        rslot_next   = rslot_reg;
        rcode_next   = rcode_reg;
        key_we       = 1'b0;
        key_waddr    = count_reg[IDX_W-1:0];
        key_wdata    = key_reg;
        st_we        = 1'b0;
        st_waddr     = count_reg[IDX_W-1:0];
        st_wdata     = ttrrd_pkg::ST_WAITING;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (opcode)
                        ttrrd_pkg::OP_CREATE:
                        begin
                            if (count_reg >= CNT_W'(MAX_TASKS))
                            begin
                                done_next  = 1'b1;
                                rslot_next = 3'd0;
                                rcode_next = ttrrd_pkg::RC_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                // empty table: nothing to search
                                key_we     = 1'b1;
                                key_wdata  = key_in;
                                st_we      = 1'b1;
                                count_next = count_reg + 1'b1;
                                done_next  = 1'b1;
                                rslot_next = 3'd0;
                                rcode_next = ttrrd_pkg::RC_OK;
                            end
                            else
                            begin
                                key_next     = key_in;
                                iss_idx_next = '0;
                                iss_cnt_next = '0;
                                cmp_cnt_next = '0;
                                state_next   = S_CSCAN;
                            end
                        end
                        ttrrd_pkg::OP_START, ttrrd_pkg::OP_STOP:
                        begin
                            done_next = 1'b1;
                            if ({1'b0, slot_id} < 9'(MAX_TASKS))
                            begin
                                st_we      = 1'b1;
                                st_waddr   = slot_id[IDX_W-1:0];
                                st_wdata   = (opcode == ttrrd_pkg::OP_START) ?
                                             ttrrd_pkg::ST_WAITING : ttrrd_pkg::ST_ENDED;
                                rslot_next = slot_id[2:0];
                                rcode_next = ttrrd_pkg::RC_OK;
                            end
                            else
                            begin
                                rslot_next = 3'd0;
                                rcode_next = ttrrd_pkg::RC_RANGE;
                            end
                        end
                        ttrrd_pkg::OP_DISPATCH:
                        begin
                            iss_idx_next = scan_reg;
                            iss_cnt_next = '0;
                            cmp_cnt_next = '0;
                            state_next   = S_DSCAN;
                        end
                        ttrrd_pkg::OP_REPORT:
                        begin
                            st_we      = 1'b1;
                            st_waddr   = run_reg;
                            st_wdata   = new_status;
                            done_next  = 1'b1;
                            rslot_next = run_ext[2:0];
                            rcode_next = ttrrd_pkg::RC_OK;
                        end
                        default:
                        begin
                            done_next  = 1'b1;
                            rslot_next = 3'd0;
                            rcode_next = ttrrd_pkg::RC_OK;
                        end
                    endcase
                end
            end
            S_CSCAN, S_DSCAN:
            begin
                // issue one read per cycle; check the previous read's data
                if (iss_cnt_reg < limit)
                begin
                    iss_idx_next = iss_wrap;
                    iss_cnt_next = iss_cnt_reg + 1'b1;
                    cmp_idx_next = iss_idx_reg;
                    pend_next    = 1'b1;
                end
                if (pend_reg)
                begin
                    cmp_cnt_next = cmp_cnt_reg + 1'b1;
                    if (hit)
                    begin
                        done_next  = 1'b1;
                        rslot_next = cmp_ext[2:0];
                        state_next = S_IDLE;
                        if (state_reg == S_CSCAN)
                        begin
                            rcode_next = ttrrd_pkg::RC_EXISTS;
                        end
                        else
                        begin
                            rcode_next = ttrrd_pkg::RC_OK;
                            run_next   = cmp_idx_reg;
                            scan_next  = cmp_wrap;
                        end
                    end
                    else if (cmp_cnt_reg == last_cnt)
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                        if (state_reg == S_CSCAN)
                        begin
                            // new key: fill the next free slot
                            key_we     = 1'b1;
                            st_we      = 1'b1;
                            count_next = count_reg + 1'b1;
                            rslot_next = cnt_ext[2:0];
                            rcode_next = ttrrd_pkg::RC_OK;
                        end
                        else
                        begin
                            rslot_next = 3'd0;
                            rcode_next = ttrrd_pkg::RC_NONE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            scan_reg    <= '0;
            run_reg     <= '0;
            iss_idx_reg <= '0;
            iss_cnt_reg <= '0;
            cmp_cnt_reg <= '0;
            pend_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            scan_reg    <= scan_next;
            run_reg     <= run_next;
            iss_idx_reg <= iss_idx_next;
            iss_cnt_reg <= iss_cnt_next;
            cmp_cnt_reg <= cmp_cnt_next;
            pend_reg    <= pend_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        cmp_idx_reg <= cmp_idx_next;
        rslot_reg   <= rslot_next;
        rcode_reg   <= rcode_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign result_slot = rslot_reg;
    assign result_code = rcode_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("result word while a scan is still running");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TASKS))
        else $error("task count beyond table size");

    a_cmd_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done_reg || state_reg != S_IDLE))
        else $error("accepted command neither answered nor in progress");

    a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (rcode_reg == ttrrd_pkg::RC_FULL || rcode_reg == ttrrd_pkg::RC_NONE))
        |-> rslot_reg == 3'd0)
        else $error("full or none result with nonzero slot");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> iss_cnt_reg <= limit)
        else $error("scan issued more reads than slots");

endmodule

`default_nettype wire

[src/ttrrd_ram.sv]
// ----------------------------------------------------------------------------
// ttrrd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ttrrd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[src/ttrrd_stat.sv]
// ----------------------------------------------------------------------------
// ttrrd_stat
// Status store: RAM plus per-entry valid bits so unwritten entries read as
// waiting right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ttrrd_stat #(
    parameter int DEPTH = ttrrd_pkg::MAX_TASKS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [1:0]    wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [1:0]    rdata
);

    logic [DEPTH-1:0] valid_reg;
    logic             rd_valid_reg;
    logic [1:0]       ram_q;

    ttrrd_ram #(
        .WIDTH (2),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[raddr];
        end
    end

    assign rdata = rd_valid_reg ? ram_q : ttrrd_pkg::ST_WAITING;

endmodule

`default_nettype wire
